>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DAMS_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define DAMS_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/dams_pkg.sv
// ----------------------------------------------------------------------------
// dams_pkg
// Operation codes, field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package dams_pkg;

  localparam int OP_W   = 3;
  localparam int KEY_W  = 10;
  localparam int VAL_W  = 64;
  localparam int CNT_W  = 11;
  localparam int WORD_W = 64;
  localparam int LO_W   = 6;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [OP_W-1:0] OP_SET        = 3'd0;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_FIRST = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_NEXT  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  typedef struct packed {
    logic accept;
    logic row_zero;
    logic row_start;
    logic row_inc;
    logic bm_rd_key;
    logic bm_rd_start;
    logic bm_rd_next;
    logic bm_wr_zero;
    logic bm_wr_set;
    logic bm_wr_clr;
    logic vs_wr;
    logic vs_rd_key;
    logic vs_rd_hit;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic found_set;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            key_oor;
    logic            cnt_zero;
    logic            enum_done;
    logic            start_end;
    logic            bit_set;
    logic            row_hit;
    logic            last_row;
    logic            out_free;
  } sts_t;

  // lowest set bit position
  function automatic logic [LO_W-1:0] ffs_word(input logic [WORD_W-1:0] w);
    logic [LO_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = LO_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dams_ram.sv
// ----------------------------------------------------------------------------
// dams_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dams_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/dams_ctrl.sv
// ----------------------------------------------------------------------------
// dams_ctrl
// Operation sequencer: clearing sweeps, read-modify-write, lookup, row scan.
// ----------------------------------------------------------------------------
`default_nettype none

module dams_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire dams_pkg::sts_t sts,
  output dams_pkg::cmd_t      cmd
);
  import dams_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_RMW   = 4'd3;
  localparam logic [3:0] S_LOOK  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_FETCH = 4'd6;
  localparam logic [3:0] S_SWEEP = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.bm_wr_zero = 1'b1;
        cmd.row_inc    = 1'b1;
        if (sts.last_row) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_SET, OP_ERASE: begin
            if (sts.key_oor) begin
              state_nxt = S_DONE;
            end else begin
              cmd.bm_rd_key = 1'b1;
              state_nxt     = S_RMW;
            end
          end
          OP_LOOKUP: begin
            if (sts.key_oor) begin
              state_nxt = S_DONE;
            end else begin
              cmd.bm_rd_key = 1'b1;
              cmd.vs_rd_key = 1'b1;
              state_nxt     = S_LOOK;
            end
          end
          OP_FIND_FIRST: begin
            if (sts.cnt_zero) begin
              state_nxt = S_DONE;
            end else begin
              cmd.row_start   = 1'b1;
              cmd.bm_rd_start = 1'b1;
              state_nxt       = S_SCAN;
            end
          end
          OP_FIND_NEXT: begin
            if (sts.key_oor || sts.enum_done || sts.start_end) begin
              state_nxt = S_DONE;
            end else begin
              cmd.row_start   = 1'b1;
              cmd.bm_rd_start = 1'b1;
              state_nxt       = S_SCAN;
            end
          end
          OP_CLEAR: begin
            cmd.row_zero = 1'b1;
            cmd.cnt_clr  = 1'b1;
            state_nxt    = S_SWEEP;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RMW: begin
        if (sts.op == OP_SET) begin
          cmd.vs_wr = 1'b1;
          if (!sts.bit_set) begin
            cmd.bm_wr_set = 1'b1;
            cmd.cnt_inc   = 1'b1;
          end
        end else if (sts.bit_set) begin
          cmd.bm_wr_clr = 1'b1;
          cmd.cnt_dec   = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_LOOK: begin
        cmd.found_set = sts.bit_set;
        state_nxt     = S_DONE;
      end
      S_SCAN: begin
        if (sts.row_hit) begin
          cmd.vs_rd_hit = 1'b1;
          cmd.found_set = 1'b1;
          state_nxt     = S_FETCH;
        end else if (sts.last_row) begin
          state_nxt = S_DONE;
        end else begin
          cmd.bm_rd_next = 1'b1;
          cmd.row_inc    = 1'b1;
        end
      end
      S_FETCH: begin
        state_nxt = S_DONE;
      end
      S_SWEEP: begin
        cmd.bm_wr_zero = 1'b1;
        cmd.row_inc    = 1'b1;
        if (sts.last_row) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/dams_dp.sv
// ----------------------------------------------------------------------------
// dams_dp
// Datapath: item registers, presence bitmap and value RAMs, count, result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dams_dp #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [dams_pkg::OP_W-1:0]   in_op,
  input  wire logic [dams_pkg::KEY_W-1:0]  in_key_in,
  input  wire logic [dams_pkg::VAL_W-1:0]  in_value_in,
  input  wire logic [dams_pkg::CNT_W-1:0]  in_enumerated_in,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic                             out_found,
  output logic      [dams_pkg::KEY_W-1:0]  out_key_out,
  output logic      [dams_pkg::VAL_W-1:0]  out_value_out,
  output logic      [dams_pkg::CNT_W-1:0]  out_enumerated_out,
  output logic      [dams_pkg::CNT_W-1:0]  out_live_count,
  output logic                             out_key_out_of_range,
  input  wire dams_pkg::cmd_t              cmd,
  output dams_pkg::sts_t                   sts
);
  import dams_pkg::*;

  localparam int KW   = $clog2(TABLE_DEPTH);
  localparam int KXW  = ((KW > KEY_W) ? KW : KEY_W) + 1;
  localparam int ROWS = (TABLE_DEPTH + WORD_W - 1) / WORD_W;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW   = RW + LO_W;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMW  = (CW > CNT_W) ? CW : CNT_W;

  logic [OP_W-1:0]        op_r;
  logic [KEY_W-1:0]       key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CNT_W-1:0]       enm_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic [RW-1:0]          row_r;
  logic [RW-1:0]          row_nxt;
  logic                   first_r;
  logic                   found_r;
  logic [IW-1:0]          hit_r;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [KEY_W-1:0]       out_key_r;
  logic [VAL_W-1:0]       out_value_r;
  logic [CNT_W-1:0]       out_enm_r;
  logic [CNT_W-1:0]       out_cnt_r;
  logic                   out_oor_r;

  logic [KXW-1:0]         key_ext;
  logic [KXW-1:0]         start_ix;
  logic [IW-1:0]          key_ix;
  logic [IW-1:0]          start_pad;
  logic [RW-1:0]          key_row;
  logic [RW-1:0]          start_row;
  logic [LO_W-1:0]        key_lo;
  logic [LO_W-1:0]        start_lo;
  logic [WORD_W-1:0]      bit_mask;
  logic [WORD_W-1:0]      scan_word;
  logic [IW-1:0]          hit_ix;
  logic [CNT_W-1:0]       enm_sat;
  logic                   key_oor;
  logic                   oor_op;
  logic                   is_find;

  logic                   bm_wr_en;
  logic [RW-1:0]          bm_wr_addr;
  logic [WORD_W-1:0]      bm_wr_data;
  logic                   bm_rd_en;
  logic [RW-1:0]          bm_rd_addr;
  logic [WORD_W-1:0]      bm_rd_data;

  logic                   vs_rd_en;
  logic [KW-1:0]          vs_rd_addr;
  logic [VALUE_WIDTH-1:0] vs_rd_data;

  always_comb begin
    key_ext   = KXW'(key_r);
    start_ix  = (op_r == OP_FIND_NEXT) ? (key_ext + KXW'(1)) : '0;
    key_ix    = IW'(key_ext);
    start_pad = IW'(start_ix);
    key_row   = key_ix[IW-1:LO_W];
    key_lo    = key_ix[LO_W-1:0];
    start_row = start_pad[IW-1:LO_W];
    start_lo  = start_pad[LO_W-1:0];
    bit_mask  = WORD_W'(1) << key_lo;
    scan_word = first_r ? (bm_rd_data & ('1 << start_lo)) : bm_rd_data;
    hit_ix    = {row_r, ffs_word(scan_word)};
    enm_sat   = (enm_r == CNT_MAX) ? CNT_MAX : (enm_r + CNT_W'(1));
    key_oor   = (key_ext >= KXW'(TABLE_DEPTH));
    oor_op    = (op_r inside {OP_SET, OP_ERASE, OP_LOOKUP, OP_FIND_NEXT});
    is_find   = (op_r inside {OP_FIND_FIRST, OP_FIND_NEXT});
  end

  always_comb begin
    bm_wr_en   = cmd.bm_wr_zero || cmd.bm_wr_set || cmd.bm_wr_clr;
    bm_wr_addr = cmd.bm_wr_zero ? row_r : key_row;
    if (cmd.bm_wr_zero) begin
      bm_wr_data = '0;
    end else if (cmd.bm_wr_set) begin
      bm_wr_data = bm_rd_data | bit_mask;
    end else begin
      bm_wr_data = bm_rd_data & ~bit_mask;
    end
    bm_rd_en = cmd.bm_rd_key || cmd.bm_rd_start || cmd.bm_rd_next;
    if (cmd.bm_rd_key) begin
      bm_rd_addr = key_row;
    end else if (cmd.bm_rd_start) begin
      bm_rd_addr = start_row;
    end else begin
      bm_rd_addr = row_r + RW'(1);
    end
    vs_rd_en   = cmd.vs_rd_key || cmd.vs_rd_hit;
    vs_rd_addr = cmd.vs_rd_hit ? KW'(hit_ix) : KW'(key_ext);
  end

  dams_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (bm_wr_en),
    .wr_addr (bm_wr_addr),
    .wr_data (bm_wr_data),
    .rd_en   (bm_rd_en),
    .rd_addr (bm_rd_addr),
    .rd_data (bm_rd_data)
  );

  dams_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_values (
    .clk     (clk),
    .wr_en   (cmd.vs_wr),
    .wr_addr (KW'(key_ext)),
    .wr_data (val_r),
    .rd_en   (vs_rd_en),
    .rd_addr (vs_rd_addr),
    .rd_data (vs_rd_data)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
    row_nxt = row_r;
    if (cmd.row_zero) begin
      row_nxt = '0;
    end else if (cmd.row_start) begin
      row_nxt = start_row;
    end else if (cmd.row_inc) begin
      row_nxt = row_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_op;
      key_r <= in_key_in;
      val_r <= in_value_in[VALUE_WIDTH-1:0];
      enm_r <= in_enumerated_in;
    end
    if (cmd.vs_rd_hit) begin
      hit_r <= hit_ix;
    end
    if (cmd.res_load) begin
      out_found_r <= found_r;
      out_key_r   <= (found_r && is_find) ? KEY_W'(hit_r) : '0;
      out_value_r <= found_r ? VAL_W'(vs_rd_data) : '0;
      out_enm_r   <= (op_r == OP_FIND_NEXT) ? enm_sat : '0;
      out_cnt_r   <= CNT_W'(count_r);
      out_oor_r   <= oor_op && key_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      row_r       <= '0;
      first_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      row_r   <= row_nxt;
      if (cmd.row_start) begin
        first_r <= 1'b1;
      end else if (cmd.row_inc) begin
        first_r <= 1'b0;
      end
      if (cmd.accept) begin
        found_r <= 1'b0;
      end else if (cmd.found_set) begin
        found_r <= 1'b1;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.op        = op_r;
    sts.key_oor   = key_oor;
    sts.cnt_zero  = (count_r == '0);
    sts.enum_done = (CMW'(enm_r) >= CMW'(count_r));
    sts.start_end = ((key_ext + KXW'(1)) >= KXW'(TABLE_DEPTH));
    sts.bit_set   = bm_rd_data[key_lo];
    sts.row_hit   = |scan_word;
    sts.last_row  = (row_r == RW'(ROWS - 1));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_key_out          = out_key_r;
  assign out_value_out        = out_value_r;
  assign out_enumerated_out   = out_enm_r;
  assign out_live_count       = out_cnt_r;
  assign out_key_out_of_range = out_oor_r;

  `DAMS_ASSERT_IMP(a_cnt_no_overflow, cmd.cnt_inc, count_r < CW'(TABLE_DEPTH))
  `DAMS_ASSERT_IMP(a_cnt_no_underflow, cmd.cnt_dec, count_r != '0)
  `DAMS_ASSERT_IMP(a_hit_from_row, cmd.vs_rd_hit, sts.row_hit && found_r == 1'b0)

endmodule

`default_nettype wire

>>> rtl/core/direct_address_map_with_scan_unit.sv
// ----------------------------------------------------------------------------
// direct_address_map_with_scan_unit
// Direct-address map with presence bitmap, live count and ordered key scan.
// ----------------------------------------------------------------------------
// Order, transfer to result: set and erase read and rewrite the bitmap row; lookup
//   reads bitmap and value; find reads 64-key bitmap rows, then the value on a hit.
// Clear: one bitmap row zeroed per cycle.
// Flow: one item in flight; the next transfer can be taken the cycle after the result loads.
// Reset: bitmap clearing pass over every row, input stalled.
`default_nettype none

`include "assert_macros.svh"

module direct_address_map_with_scan_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [dams_pkg::OP_W-1:0]   in_op,
  input  wire logic [dams_pkg::KEY_W-1:0]  in_key_in,
  input  wire logic [dams_pkg::VAL_W-1:0]  in_value_in,
  input  wire logic [dams_pkg::CNT_W-1:0]  in_enumerated_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_found,
  output logic      [dams_pkg::KEY_W-1:0]  out_key_out,
  output logic      [dams_pkg::VAL_W-1:0]  out_value_out,
  output logic      [dams_pkg::CNT_W-1:0]  out_enumerated_out,
  output logic      [dams_pkg::CNT_W-1:0]  out_live_count,
  output logic                             out_key_out_of_range
);
  import dams_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dams_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dams_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_op                (in_op),
    .in_key_in            (in_key_in),
    .in_value_in          (in_value_in),
    .in_enumerated_in     (in_enumerated_in),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_found            (out_found),
    .out_key_out          (out_key_out),
    .out_value_out        (out_value_out),
    .out_enumerated_out   (out_enumerated_out),
    .out_live_count       (out_live_count),
    .out_key_out_of_range (out_key_out_of_range),
    .cmd                  (cmd),
    .sts                  (sts)
  );

  `DAMS_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall)
  `DAMS_ASSERT_IMP(a_load_when_free, cmd.res_load, sts.out_free)
  `DAMS_ASSERT_IMP(a_accept_idle, cmd.accept, !in_stall && in_valid)

endmodule

`default_nettype wire
